### hdl/button_debounce_menu_controller_assert.svh
// Assertion macros shared by the controller RTL.
`ifndef BUTTON_DEBOUNCE_MENU_CONTROLLER_ASSERT_SVH
`define BUTTON_DEBOUNCE_MENU_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define BDMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define BDMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bdmc_pkg.sv
`default_nettype none

package bdmc_pkg;

   // Fixed field widths
   localparam int TEMP_WIDTH = 12;
   localparam int CMP_WIDTH  = 17;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Reset values of the registers
   localparam logic [7:0]                   PRESS_TICKS_RESET   = 8'd4;
   localparam logic [6:0]                   REPEAT_DELAY_RESET  = 7'd100;
   localparam logic [6:0]                   REPEAT_PERIOD_RESET = 7'd2;
   localparam logic signed [TEMP_WIDTH-1:0] TEMP_MAX_RESET      = 12'sd1000;
   localparam logic signed [TEMP_WIDTH-1:0] TEMP_MIN_RESET      = -12'sd300;

   // Serial command bytes
   localparam logic [7:0] CMD_UP    = 8'h77;
   localparam logic [7:0] CMD_DOWN  = 8'h73;
   localparam logic [7:0] CMD_ENTER = 8'h7a;

   // Register indexes
   localparam logic [2:0] REG_PRESS_TICKS   = 3'd0;
   localparam logic [2:0] REG_REPEAT_DELAY  = 3'd1;
   localparam logic [2:0] REG_REPEAT_PERIOD = 3'd2;
   localparam logic [2:0] REG_TEMP_MAX      = 3'd3;
   localparam logic [2:0] REG_TEMP_MIN      = 3'd4;

   typedef enum logic [1:0] {
      MENU_CURRENT  = 2'd0,
      MENU_SET_TEMP = 2'd1,
      MENU_SET_MODE = 2'd2
   } menu_state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_UP,
      ACT_DOWN,
      ACT_ENTER,
      ACT_HOLD_UP,
      ACT_HOLD_DOWN,
      ACT_HOLD_ENTER
   } act_type;

   typedef struct packed {
      logic       up_pin;
      logic       down_pin;
      logic       enter_pin;
      logic [7:0] serial_cmd;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                   menu_state;
      logic signed [TEMP_WIDTH-1:0] pending_temperature;
      logic                         pending_mode;
      logic                         commit_temperature;
      logic                         commit_mode;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] press_ticks;
      logic [6:0] repeat_delay;
      logic [6:0] repeat_period;
   } btn_cfg_type;

   typedef struct packed {
      logic press;
      logic hold;
   } btn_fire_type;

   typedef struct packed {
      menu_state_type        menu;
      logic [TEMP_WIDTH-1:0] temp;
      logic                  mode;
      logic                  commit_t;
      logic                  commit_m;
   } menu_ctx_type;

   // Apply one action to the menu context
   function automatic menu_ctx_type menu_apply(
      input menu_ctx_type                 ctx,
      input act_type                      act,
      input logic signed [TEMP_WIDTH-1:0] tmax,
      input logic signed [TEMP_WIDTH-1:0] tmin
   );
      menu_ctx_type res;
      logic         step;
      logic         up;
      res  = ctx;
      step = 1'b0;
      up   = 1'b0;
      case (act)
         ACT_UP: begin
            step = 1'b1;
            up   = 1'b1;
         end
         ACT_DOWN: begin
            step = 1'b1;
         end
         ACT_HOLD_UP: begin
            if (ctx.menu == MENU_SET_TEMP) begin
               step = 1'b1;
               up   = 1'b1;
            end
         end
         ACT_HOLD_DOWN: begin
            if (ctx.menu == MENU_SET_TEMP) begin
               step = 1'b1;
            end
         end
         ACT_ENTER: begin
            if (ctx.menu == MENU_SET_TEMP) begin
               res.menu     = MENU_CURRENT;
               res.commit_t = 1'b1;
            end else if (ctx.menu == MENU_SET_MODE) begin
               res.menu     = MENU_CURRENT;
               res.commit_m = 1'b1;
            end
         end
         ACT_HOLD_ENTER: begin
            if (ctx.menu == MENU_CURRENT) begin
               res.menu = MENU_SET_MODE;
            end
         end
         default: ;
      endcase
      // Step the temperature or toggle the mode
      if (step) begin
         if (ctx.menu == MENU_CURRENT || ctx.menu == MENU_SET_TEMP) begin
            res.menu = MENU_SET_TEMP;
            if (up) begin
               if ($signed(ctx.temp) < tmax) begin
                  res.temp = ctx.temp + TEMP_WIDTH'(1);
               end
            end else begin
               if ($signed(ctx.temp) > tmin) begin
                  res.temp = ctx.temp - TEMP_WIDTH'(1);
               end
            end
         end else if (ctx.menu == MENU_SET_MODE) begin
            res.mode = ~ctx.mode;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### hdl/button_debounce_menu_controller.sv
// Channel  Direction  Handshake          Word
// req      in         req_valid/ready    req_word: up_pin, down_pin, enter_pin, serial_cmd
// rsp      out        rsp_valid/ready    rsp_word: menu_state, pending_temperature, ...
// csr      in         APB, pready high   5 registers at byte address 4*index
//
// One word per cycle while rsp is not stalled. An input register and a result
// register hold the word, with the serial action and six button actions chained between.
// Synchronous reset clears debounce counters, menu, temperature, mode and both stages;
// it presets the hold counters from the reset repeat delay.
// A stalled rsp holds the result; the input register takes one more word, then
// req_ready drops until rsp_ready returns.
`default_nettype none

module button_debounce_menu_controller
   import bdmc_pkg::*;
#(
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire req_word_type          req_word,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      rsp_word_type          rsp_word,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   `include "button_debounce_menu_controller_assert.svh"

   logic                         s1_valid_ff, s1_valid_in;
   req_word_type                 s1_word_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff, rsp_word_in;
   menu_state_type               menu_ff, menu_in;
   logic [TEMP_WIDTH-1:0]        temp_ff, temp_in;
   logic                         mode_ff, mode_in;
   logic                         advance;
   logic                         csr_write;
   logic [2:0]                   csr_index;
   logic [7:0]                   press_ticks_ff;
   logic [6:0]                   repeat_delay_ff;
   logic [6:0]                   repeat_period_ff;
   logic signed [TEMP_WIDTH-1:0] temp_max_ff;
   logic signed [TEMP_WIDTH-1:0] temp_min_ff;
   btn_cfg_type                  btn_cfg;
   btn_fire_type                 fire_up, fire_down, fire_enter;
   act_type                      acts [7];
   menu_ctx_type                 ctx [8];

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ticks_ff   <= PRESS_TICKS_RESET;
         repeat_delay_ff  <= REPEAT_DELAY_RESET;
         repeat_period_ff <= REPEAT_PERIOD_RESET;
         temp_max_ff      <= TEMP_MAX_RESET;
         temp_min_ff      <= TEMP_MIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PRESS_TICKS:   press_ticks_ff   <= csr_pwdata[7:0];
            REG_REPEAT_DELAY:  repeat_delay_ff  <= csr_pwdata[6:0];
            REG_REPEAT_PERIOD: repeat_period_ff <= csr_pwdata[6:0];
            REG_TEMP_MAX:      temp_max_ff      <= csr_pwdata[TEMP_WIDTH-1:0];
            REG_TEMP_MIN:      temp_min_ff      <= csr_pwdata[TEMP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PRESS_TICKS:   csr_prdata = CSR_DATA_W'(press_ticks_ff);
         REG_REPEAT_DELAY:  csr_prdata = CSR_DATA_W'(repeat_delay_ff);
         REG_REPEAT_PERIOD: csr_prdata = CSR_DATA_W'(repeat_period_ff);
         REG_TEMP_MAX:
            csr_prdata = {{(CSR_DATA_W-TEMP_WIDTH){temp_max_ff[TEMP_WIDTH-1]}}, temp_max_ff};
         REG_TEMP_MIN:
            csr_prdata = {{(CSR_DATA_W-TEMP_WIDTH){temp_min_ff[TEMP_WIDTH-1]}}, temp_min_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // Handshake: process the held word whenever the result slot frees up
   assign advance     = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready   = ~s1_valid_ff | advance;
   assign s1_valid_in = (req_valid & req_ready) | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         s1_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Button scanners
   assign btn_cfg.press_ticks   = press_ticks_ff;
   assign btn_cfg.repeat_delay  = repeat_delay_ff;
   assign btn_cfg.repeat_period = repeat_period_ff;

   bdmc_button #(.COUNT_WIDTH(COUNT_WIDTH)) u_btn_up (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .pin     (s1_word_ff.up_pin),
      .cfg     (btn_cfg),
      .fire    (fire_up)
   );

   bdmc_button #(.COUNT_WIDTH(COUNT_WIDTH)) u_btn_down (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .pin     (s1_word_ff.down_pin),
      .cfg     (btn_cfg),
      .fire    (fire_down)
   );

   bdmc_button #(.COUNT_WIDTH(COUNT_WIDTH)) u_btn_enter (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .pin     (s1_word_ff.enter_pin),
      .cfg     (btn_cfg),
      .fire    (fire_enter)
   );

   // Order the actions: serial byte first, then up, down, enter
   always_comb begin
      case (s1_word_ff.serial_cmd)
         CMD_UP:    acts[0] = ACT_UP;
         CMD_DOWN:  acts[0] = ACT_DOWN;
         CMD_ENTER: acts[0] = ACT_ENTER;
         default:   acts[0] = ACT_NONE;
      endcase
      acts[1] = fire_up.press    ? ACT_UP         : ACT_NONE;
      acts[2] = fire_up.hold     ? ACT_HOLD_UP    : ACT_NONE;
      acts[3] = fire_down.press  ? ACT_DOWN       : ACT_NONE;
      acts[4] = fire_down.hold   ? ACT_HOLD_DOWN  : ACT_NONE;
      acts[5] = fire_enter.press ? ACT_ENTER      : ACT_NONE;
      acts[6] = fire_enter.hold  ? ACT_HOLD_ENTER : ACT_NONE;
   end

   // Run the menu through the chain of actions
   always_comb begin
      ctx[0].menu     = menu_ff;
      ctx[0].temp     = temp_ff;
      ctx[0].mode     = mode_ff;
      ctx[0].commit_t = 1'b0;
      ctx[0].commit_m = 1'b0;
      for (int i = 0; i < 7; i++) begin
         ctx[i+1] = menu_apply(ctx[i], acts[i], temp_max_ff, temp_min_ff);
      end
      menu_in = ctx[7].menu;
      temp_in = ctx[7].temp;
      mode_in = ctx[7].mode;
      rsp_word_in.menu_state          = ctx[7].menu;
      rsp_word_in.pending_temperature = ctx[7].temp;
      rsp_word_in.pending_mode        = ctx[7].mode;
      rsp_word_in.commit_temperature  = ctx[7].commit_t;
      rsp_word_in.commit_mode         = ctx[7].commit_m;
   end

   // Menu state register
   always_ff @(posedge clock) begin
      if (reset) begin
         menu_ff <= MENU_CURRENT;
         temp_ff <= '0;
         mode_ff <= 1'b0;
      end else if (advance) begin
         menu_ff <= menu_in;
         temp_ff <= temp_in;
         mode_ff <= mode_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `BDMC_ASSERT_NEXT(a_result_follows, clock, reset, advance, rsp_valid_ff,
      "processed word did not produce a result")
   `BDMC_ASSERT_NEXT(a_state_holds, clock, reset, !advance,
      $stable(menu_ff) && $stable(temp_ff) && $stable(mode_ff),
      "menu state changed without a processed word")
   `BDMC_ASSERT_NEXT(a_input_holds, clock, reset, s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_word_ff), "held input word lost or changed")
   `BDMC_ASSERT_NOW(a_empty_ready, clock, reset, !s1_valid_ff, req_ready,
      "empty input register refused a word")

endmodule

`default_nettype wire

### hdl/bdmc_button.sv
`default_nettype none

module bdmc_button
   import bdmc_pkg::*;
#(
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         pin,
   input  wire btn_cfg_type  cfg,
   output btn_fire_type      fire
);

   logic [COUNT_WIDTH-1:0] debounce_ff, debounce_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;
   logic [COUNT_WIDTH-1:0] hold_inc;
   logic [COUNT_WIDTH-1:0] hold_release;
   logic [COUNT_WIDTH-1:0] hold_start;
   logic [CMP_WIDTH-1:0]   neg_wait;
   logic [CMP_WIDTH-1:0]   neg_wait_reset;
   logic [CMP_WIDTH-1:0]   hold_ext;

   // Released value of the hold counter, now and at reset
   assign neg_wait       = CMP_WIDTH'(0) - CMP_WIDTH'(cfg.repeat_delay);
   assign neg_wait_reset = CMP_WIDTH'(0) - CMP_WIDTH'(REPEAT_DELAY_RESET);
   assign hold_release   = neg_wait[COUNT_WIDTH-1:0];
   assign hold_start     = neg_wait_reset[COUNT_WIDTH-1:0];

   assign hold_inc = hold_ff + COUNT_WIDTH'(1);
   assign hold_ext = {{(CMP_WIDTH-COUNT_WIDTH){hold_inc[COUNT_WIDTH-1]}}, hold_inc};

   // Debounce, fire the press once, then repeat the hold action
   always_comb begin
      debounce_in = debounce_ff;
      done_in     = done_ff;
      hold_in     = hold_ff;
      fire        = '0;
      if (pin) begin
         debounce_in = '0;
         done_in     = 1'b0;
         hold_in     = hold_release;
      end else if (CMP_WIDTH'(debounce_ff) < CMP_WIDTH'(cfg.press_ticks)) begin
         debounce_in = debounce_ff + COUNT_WIDTH'(1);
      end else begin
         fire.press = ~done_ff;
         done_in    = 1'b1;
         if ($signed(hold_ext) > $signed(CMP_WIDTH'(cfg.repeat_period))) begin
            hold_in   = '0;
            fire.hold = 1'b1;
         end else begin
            hold_in = hold_inc;
         end
      end
   end

   // Update only when the word is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= '0;
         done_ff     <= 1'b0;
         hold_ff     <= hold_start;
      end else if (advance) begin
         debounce_ff <= debounce_in;
         done_ff     <= done_in;
         hold_ff     <= hold_in;
      end
   end

endmodule

`default_nettype wire

### sim/tb_button_debounce_menu_controller.sv
module tb_button_debounce_menu_controller
   import bdmc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Button slots in scan order
   localparam int BTN_UP    = 0;
   localparam int BTN_DOWN  = 1;
   localparam int BTN_ENTER = 2;

   // Serial bytes beside the three commands
   localparam logic [7:0] CMD_IDLE = 8'h00;
   localparam logic [7:0] CMD_JUNK = 8'hff;

   // Address with no register behind it
   localparam logic [2:0] REG_SPARE = 3'd5;

   localparam int TEMP_TOP        = 2047;
   localparam int TEMP_BOTTOM     = -2048;
   localparam int RANDOM_WORDS    = 1750;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int IDLE_CYCLES     = 4;
   localparam int LIMIT_NS        = 5_000_000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_word;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Register copies
   logic [7:0]                   cfg_debounce;
   logic [6:0]                   cfg_repeat_delay;
   logic [6:0]                   cfg_repeat_period;
   logic signed [TEMP_WIDTH-1:0] cfg_temp_max;
   logic signed [TEMP_WIDTH-1:0] cfg_temp_min;

   // Button and menu state of the predictor
   logic [7:0]                   db_cnt [3];
   logic                         press_seen [3];
   logic signed [7:0]            hold_cnt [3];
   menu_state_type               menu_now;
   logic signed [TEMP_WIDTH-1:0] temp_now;
   logic                         mode_now;
   logic                         commit_t_now;
   logic                         commit_m_now;

   rsp_word_type pending_menu_words [$];
   int           fail_count;
   int           words_sent;
   logic         send_gaps_on;
   logic         recv_gaps_on;
   logic         hold_off_req;

   button_debounce_menu_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Up or down step: edit temperature in states 0 and 1, toggle mode in state 2
   function automatic void step_temp(input logic up);
      if (menu_now == MENU_CURRENT || menu_now == MENU_SET_TEMP) begin
         menu_now = MENU_SET_TEMP;
         if (up) begin
            if (temp_now < cfg_temp_max) temp_now = temp_now + 12'sd1;
         end else begin
            if (temp_now > cfg_temp_min) temp_now = temp_now - 12'sd1;
         end
      end else if (menu_now == MENU_SET_MODE) begin
         mode_now = ~mode_now;
      end
   endfunction

   function automatic void enter_press();
      if (menu_now == MENU_SET_TEMP) begin
         menu_now     = MENU_CURRENT;
         commit_t_now = 1'b1;
      end else if (menu_now == MENU_SET_MODE) begin
         menu_now     = MENU_CURRENT;
         commit_m_now = 1'b1;
      end
   endfunction

   // Debounce one button, then fire its press once and its hold repeatedly
   function automatic void scan_button(input int b, input logic pin);
      if (pin) begin
         db_cnt[b]     = 8'd0;
         press_seen[b] = 1'b0;
         hold_cnt[b]   = 8'(-int'(cfg_repeat_delay));
      end else if (db_cnt[b] < cfg_debounce) begin
         db_cnt[b] = db_cnt[b] + 8'd1;
      end else begin
         if (!press_seen[b]) begin
            press_seen[b] = 1'b1;
            if (b == BTN_UP) step_temp(1'b1);
            else if (b == BTN_DOWN) step_temp(1'b0);
            else enter_press();
         end
         hold_cnt[b] = hold_cnt[b] + 8'sd1;
         if (int'(hold_cnt[b]) > int'(cfg_repeat_period)) begin
            hold_cnt[b] = 8'sd0;
            if (b == BTN_ENTER) begin
               if (menu_now == MENU_CURRENT) menu_now = MENU_SET_MODE;
            end else if (menu_now == MENU_SET_TEMP) begin
               step_temp(b == BTN_UP);
            end
         end
      end
   endfunction

   // Advance the menu by one scan tick and return the word it shows
   function automatic rsp_word_type predict_menu_tick(input req_word_type w);
      rsp_word_type r;
      commit_t_now = 1'b0;
      commit_m_now = 1'b0;
      case (w.serial_cmd)
         CMD_UP:    step_temp(1'b1);
         CMD_DOWN:  step_temp(1'b0);
         CMD_ENTER: enter_press();
         default: ;
      endcase
      scan_button(BTN_UP, w.up_pin);
      scan_button(BTN_DOWN, w.down_pin);
      scan_button(BTN_ENTER, w.enter_pin);
      r.menu_state          = menu_now;
      r.pending_temperature = temp_now;
      r.pending_mode        = mode_now;
      r.commit_temperature  = commit_t_now;
      r.commit_mode         = commit_m_now;
      return r;
   endfunction

   function automatic void compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_menu_word(input rsp_word_type got);
      rsp_word_type want;
      if (pending_menu_words.size() == 0) begin
         $display("%0t: result word %h with none outstanding", $time, got);
         fail_count++;
      end else begin
         want = pending_menu_words.pop_front();
         compare_field("menu_state", want.menu_state, got.menu_state);
         compare_field("pending_temperature", want.pending_temperature,
                       got.pending_temperature);
         compare_field("pending_mode", want.pending_mode, got.pending_mode);
         compare_field("commit_temperature", want.commit_temperature,
                       got.commit_temperature);
         compare_field("commit_mode", want.commit_mode, got.commit_mode);
      end
   endfunction

   function automatic logic [7:0] pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return CMD_IDLE;
      if (r < 77) return CMD_UP;
      if (r < 84) return CMD_DOWN;
      if (r < 90) return CMD_ENTER;
      return 8'($urandom_range(0, 255));
   endfunction

   // Limit a short distance from the temperature now pending
   function automatic logic signed [TEMP_WIDTH-1:0] near_temp(input int offset);
      int t;
      t = int'(temp_now) + offset;
      if (t > TEMP_TOP) t = TEMP_TOP;
      if (t < TEMP_BOTTOM) t = TEMP_BOTTOM;
      return 12'(t);
   endfunction

   // Offer one word, wait for it to be taken, and record its result
   task automatic send_word(input logic up_pin, input logic down_pin,
                            input logic enter_pin, input logic [7:0] cmd);
      req_word_type w;
      int           gap;
      w.up_pin     = up_pin;
      w.down_pin   = down_pin;
      w.enter_pin  = enter_pin;
      w.serial_cmd = cmd;
      gap = send_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_menu_words.push_back(predict_menu_tick(w));
      words_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every result is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_menu_words.size() != 0) @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_PRESS_TICKS:   cfg_debounce      = data[7:0];
         REG_REPEAT_DELAY:  cfg_repeat_delay  = data[6:0];
         REG_REPEAT_PERIOD: cfg_repeat_period = data[6:0];
         REG_TEMP_MAX:      cfg_temp_max      = data[TEMP_WIDTH-1:0];
         REG_TEMP_MIN:      cfg_temp_min      = data[TEMP_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_config(input logic [7:0] db, input logic [6:0] hw,
                               input logic [6:0] hi,
                               input logic signed [TEMP_WIDTH-1:0] tmax,
                               input logic signed [TEMP_WIDTH-1:0] tmin);
      csr_write(REG_PRESS_TICKS, 32'(db));
      csr_write(REG_REPEAT_DELAY, 32'(hw));
      csr_write(REG_REPEAT_PERIOD, 32'(hi));
      csr_write(REG_TEMP_MAX, {20'd0, tmax});
      csr_write(REG_TEMP_MIN, {20'd0, tmin});
   endtask

   // Hold one or more buttons for a number of ticks, then release
   task automatic send_gesture(input int length);
      logic [2:0] held;
      held = ($urandom_range(0, 9) < 7) ? (3'b001 << $urandom_range(0, 2))
                                        : 3'($urandom_range(1, 7));
      repeat (length) send_word(~held[2], ~held[1], ~held[0], pick_cmd());
      repeat ($urandom_range(1, 2)) send_word(1'b1, 1'b1, 1'b1, pick_cmd());
   endtask

   // Bouncing pins and arbitrary bytes
   task automatic send_noise(input int length);
      repeat (length) begin
         send_word(1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_serial_commands();
      send_word(1'b1, 1'b1, 1'b1, CMD_IDLE);
      send_word(1'b1, 1'b1, 1'b1, CMD_UP);
      send_word(1'b1, 1'b1, 1'b1, CMD_UP);
      send_word(1'b1, 1'b1, 1'b1, CMD_DOWN);
      send_word(1'b1, 1'b1, 1'b1, CMD_ENTER);
      send_word(1'b1, 1'b1, 1'b1, CMD_ENTER);
      send_word(1'b1, 1'b1, 1'b1, CMD_JUNK);
      send_word(1'b1, 1'b1, 1'b1, CMD_DOWN);
      // up held past the default debounce, then released
      repeat (6) send_word(1'b0, 1'b1, 1'b1, CMD_IDLE);
      send_word(1'b1, 1'b1, 1'b1, CMD_IDLE);
   endtask

   task automatic test_zero_debounce_hold();
      wait_idle();
      write_config(8'd0, 7'd0, 7'd0, TEMP_MAX_RESET, TEMP_MIN_RESET);
      csr_write(REG_SPARE, 32'hffff_ffff);
      // a release tick reloads the hold counters from the new wait
      send_word(1'b1, 1'b1, 1'b1, CMD_IDLE);
      // enter held: hold moves the menu to set mode
      repeat (2) send_word(1'b1, 1'b1, 1'b0, CMD_IDLE);
      send_word(1'b1, 1'b1, 1'b1, CMD_IDLE);
      // serial enter, up and enter together: both commits in one tick
      send_word(1'b0, 1'b1, 1'b0, CMD_ENTER);
      send_word(1'b1, 1'b1, 1'b1, CMD_IDLE);
   endtask

   task automatic test_crossed_limits();
      wait_idle();
      write_config(8'd0, 7'd0, 7'd0, 12'(TEMP_BOTTOM), 12'(TEMP_TOP));
      send_word(1'b1, 1'b1, 1'b1, CMD_ENTER);
      send_word(1'b1, 1'b1, 1'b1, CMD_UP);
      send_word(1'b1, 1'b1, 1'b1, CMD_DOWN);
   endtask

   task automatic test_random_sequences();
      int phase;
      int first_word;
      int phase_end;
      int deep;
      int db;
      int hw;
      int hi;
      int kind;
      phase      = 0;
      first_word = words_sent;
      while (words_sent < first_word + RANDOM_WORDS) begin
         wait_idle();
         // pick the extremes first, then random settings
         case (phase)
            0: write_config(8'd0, 7'd0, 7'd0, 12'(TEMP_TOP), 12'(TEMP_BOTTOM));
            1: write_config(8'd255, 7'd127, 7'd126, 12'(TEMP_BOTTOM), 12'(TEMP_TOP));
            default: begin
               kind = $urandom_range(0, 9);
               write_config((kind == 0) ? 8'd1 : 8'($urandom_range(0, 6)),
                            7'($urandom_range(0, 12)), 7'($urandom_range(0, 4)),
                            ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                        : near_temp($urandom_range(0, 10)),
                            ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                        : near_temp(-int'($urandom_range(0, 10))));
            end
         endcase
         send_gaps_on = ($urandom_range(0, 2) != 0);
         recv_gaps_on = ($urandom_range(0, 2) != 0);
         db   = int'(cfg_debounce);
         hw   = int'(cfg_repeat_delay);
         hi   = int'(cfg_repeat_period);
         deep = db + hw + 2 * (hi + 1) + 4;
         phase_end = words_sent + deep + $urandom_range(60, 160);
         // open with a hold long enough for repeats
         send_gesture(deep);
         while (words_sent < phase_end) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) send_gesture($urandom_range(1, db + 3));
            else if (kind < 7) send_gesture(db + 1 + $urandom_range(0, hw / 2 + 2));
            else if (kind < 9) send_gesture(db + hw + 2 + $urandom_range(0, 3 * (hi + 1)));
            else send_noise($urandom_range(1, 6));
         end
         phase++;
      end
   endtask

   task automatic test_receiver_stall();
      wait_idle();
      write_config(8'd1, 7'd3, 7'd1, near_temp(4), near_temp(-4));
      send_gaps_on = 1'b0;
      recv_gaps_on = 1'b0;
      hold_off_req = 1'b1;
      repeat (5) send_gesture(10);
   endtask

   // Take result words with random stalls and check each one
   initial begin : result_check
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         gap = recv_gaps_on ? $urandom_range(0, 14) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_menu_word(rsp_word);
         @(negedge clock);
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_word     = '1;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      fail_count   = 0;
      words_sent   = 0;
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
      hold_off_req = 1'b0;
      // predictor starts from the reset state
      cfg_debounce      = PRESS_TICKS_RESET;
      cfg_repeat_delay  = REPEAT_DELAY_RESET;
      cfg_repeat_period = REPEAT_PERIOD_RESET;
      cfg_temp_max      = TEMP_MAX_RESET;
      cfg_temp_min      = TEMP_MIN_RESET;
      for (int b = 0; b < 3; b++) begin
         db_cnt[b]     = 8'd0;
         press_seen[b] = 1'b0;
         hold_cnt[b]   = 8'(-int'(REPEAT_DELAY_RESET));
      end
      menu_now = MENU_CURRENT;
      temp_now = '0;
      mode_now = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_serial_commands();
      test_zero_debounce_hold();
      test_crossed_limits();
      test_random_sequences();
      test_receiver_stall();
      wait_idle();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
